/* sv/rpd_pkg.sv */
// package: codes, types and crc helper for the resync packet deframer
`timescale 1ns / 1ps
package rpd_pkg;

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_RESUME = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] ST_WAIT   = 2'd0;
    localparam logic [1:0] ST_FOUND  = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_REFUSE = 2'd3;

    localparam logic [7:0]  START_SHORT = 8'd2;
    localparam logic [7:0]  START_LONG  = 8'd3;
    localparam logic [7:0]  END_BYTE    = 8'd3;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] LONG_MIN    = 16'd255;
    localparam logic [9:0]  MAX_PAYLOAD_RESET = 10'd512;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_PUSHED, S_RES_USED, S_RES_APPLY, S_RES_DONE, S_RD,
        S_J0, S_H0, S_H1, S_H2, S_CHK, S_CRC, S_T0, S_T1, S_T2, S_BAD, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_PUSH, OP_BTW_DEC, OP_RES_OFF, OP_RES_USED,
        OP_RES_APPLY, OP_RD_PAY, OP_WAIT1, OP_WAIT_HDR, OP_WAIT_TOT, OP_RD_OFF0,
        OP_RD_OFF1, OP_RD_OFF2, OP_PLEN8, OP_PLEN16, OP_CRC_START, OP_CRC_STEP,
        OP_TAIL, OP_FOUND, OP_SLIDE, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] code;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       pending;
        logic       full;
        logic       rd_ok;
        logic       btw_gt1;
        logic       live_zero;
        logic       live_one;
        logic       b0_is2;
        logic       b0_is3;
        logic       hdr_short;
        logic       hdr_long;
        logic       len_bad;
        logic       tot_short;
        logic       crc_last;
        logic       trail_ok;
        logic       out_free;
    } t_sts;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* sv/rpd_channels.sv */
// interfaces: request, result and configuration channels
`timescale 1ns / 1ps
interface rpd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [8:0] read_index;
    modport source (output valid, req_type, data_byte, read_index, input ready);
    modport sink (input valid, req_type, data_byte, read_index, output ready);
endinterface

interface rpd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] payload_length;
    logic [7:0] read_data;
    modport source (output valid, status, payload_length, read_data, input ready);
    modport sink (input valid, status, payload_length, read_data, output ready);
endinterface

interface rpd_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] max_payload;
    modport source (output valid, max_payload, input ready);
    modport sink (input valid, max_payload, output ready);
endinterface

/* sv/rpd_ctrl.sv */
// controller: sequences push, resume, read and frame scan steps
`timescale 1ns / 1ps
module rpd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rpd_pkg::t_sts i_sts,
    output rpd_pkg::t_cmd o_cmd
);

    rpd_pkg::t_state r_state, n_state;
    logic [1:0]      r_code, n_code;
    rpd_pkg::t_op    op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpd_pkg::S_IDLE;
            r_code  <= rpd_pkg::ST_WAIT;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        unique case (r_state)
            rpd_pkg::S_IDLE: begin
                if (i_in_valid) n_state = rpd_pkg::S_DISP;
            end
            rpd_pkg::S_DISP: begin
                n_code  = rpd_pkg::ST_REFUSE;
                n_state = rpd_pkg::S_EMIT;
                priority if (i_sts.req == rpd_pkg::REQ_PUSH) begin
                    if (!(i_sts.pending && i_sts.full)) n_state = rpd_pkg::S_PUSHED;
                end else if (i_sts.req == rpd_pkg::REQ_RESUME) begin
                    if (i_sts.pending) n_state = rpd_pkg::S_RES_USED;
                end else if (i_sts.req == rpd_pkg::REQ_READ) begin
                    if (i_sts.pending && i_sts.rd_ok) n_state = rpd_pkg::S_RD;
                end else begin
                    n_state = rpd_pkg::S_EMIT;
                end
            end
            rpd_pkg::S_PUSHED: begin
                priority if (i_sts.pending) begin
                    n_code  = rpd_pkg::ST_FOUND;
                    n_state = rpd_pkg::S_EMIT;
                end else if (i_sts.btw_gt1) begin
                    n_code  = rpd_pkg::ST_WAIT;
                    n_state = rpd_pkg::S_EMIT;
                end else begin
                    n_state = rpd_pkg::S_J0;
                end
            end
            rpd_pkg::S_RES_USED:  n_state = rpd_pkg::S_RES_APPLY;
            rpd_pkg::S_RES_APPLY: n_state = rpd_pkg::S_RES_DONE;
            rpd_pkg::S_RES_DONE: begin
                if (i_sts.live_zero) begin
                    n_code  = rpd_pkg::ST_WAIT;
                    n_state = rpd_pkg::S_EMIT;
                end else begin
                    n_state = rpd_pkg::S_J0;
                end
            end
            rpd_pkg::S_RD: begin
                n_code  = rpd_pkg::ST_READ;
                n_state = rpd_pkg::S_EMIT;
            end
            rpd_pkg::S_J0: begin
                if (i_sts.live_zero) begin
                    n_code  = rpd_pkg::ST_WAIT;
                    n_state = rpd_pkg::S_EMIT;
                end else begin
                    n_state = rpd_pkg::S_H0;
                end
            end
            rpd_pkg::S_H0: begin
                priority if (!(i_sts.b0_is2 || i_sts.b0_is3)) begin
                    n_state = rpd_pkg::S_BAD;
                end else if (i_sts.hdr_short) begin
                    n_code  = rpd_pkg::ST_WAIT;
                    n_state = rpd_pkg::S_EMIT;
                end else begin
                    n_state = rpd_pkg::S_H1;
                end
            end
            rpd_pkg::S_H1: n_state = i_sts.hdr_long ? rpd_pkg::S_H2 : rpd_pkg::S_CHK;
            rpd_pkg::S_H2: n_state = rpd_pkg::S_CHK;
            rpd_pkg::S_CHK: begin
                priority if (i_sts.len_bad) begin
                    n_state = rpd_pkg::S_BAD;
                end else if (i_sts.tot_short) begin
                    n_code  = rpd_pkg::ST_WAIT;
                    n_state = rpd_pkg::S_EMIT;
                end else begin
                    n_state = rpd_pkg::S_CRC;
                end
            end
            rpd_pkg::S_CRC: begin
                if (i_sts.crc_last) n_state = rpd_pkg::S_T0;
            end
            rpd_pkg::S_T0: n_state = rpd_pkg::S_T1;
            rpd_pkg::S_T1: n_state = rpd_pkg::S_T2;
            rpd_pkg::S_T2: begin
                if (i_sts.trail_ok) begin
                    n_code  = rpd_pkg::ST_FOUND;
                    n_state = rpd_pkg::S_EMIT;
                end else begin
                    n_state = rpd_pkg::S_BAD;
                end
            end
            rpd_pkg::S_BAD: begin
                if (i_sts.live_one) begin
                    n_code  = rpd_pkg::ST_WAIT;
                    n_state = rpd_pkg::S_EMIT;
                end else begin
                    n_state = rpd_pkg::S_J0;
                end
            end
            rpd_pkg::S_EMIT: begin
                if (i_sts.out_free) n_state = rpd_pkg::S_IDLE;
            end
            default: n_state = rpd_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        op         = rpd_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            rpd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) op = rpd_pkg::OP_LATCH;
            end
            rpd_pkg::S_DISP: begin
                if (i_sts.req == rpd_pkg::REQ_PUSH && !(i_sts.pending && i_sts.full))
                    op = rpd_pkg::OP_PUSH;
                if (i_sts.req == rpd_pkg::REQ_RESUME && i_sts.pending)
                    op = rpd_pkg::OP_RES_OFF;
                if (i_sts.req == rpd_pkg::REQ_READ && i_sts.pending && i_sts.rd_ok)
                    op = rpd_pkg::OP_RD_PAY;
            end
            rpd_pkg::S_PUSHED: begin
                if (!i_sts.pending && i_sts.btw_gt1) op = rpd_pkg::OP_BTW_DEC;
            end
            rpd_pkg::S_RES_USED:  op = rpd_pkg::OP_RES_USED;
            rpd_pkg::S_RES_APPLY: op = rpd_pkg::OP_RES_APPLY;
            rpd_pkg::S_RES_DONE:  op = rpd_pkg::OP_NONE;
            rpd_pkg::S_RD:        op = rpd_pkg::OP_NONE;
            rpd_pkg::S_J0: op = i_sts.live_zero ? rpd_pkg::OP_WAIT1 : rpd_pkg::OP_RD_OFF0;
            rpd_pkg::S_H0: begin
                if (i_sts.b0_is2 || i_sts.b0_is3)
                    op = i_sts.hdr_short ? rpd_pkg::OP_WAIT_HDR : rpd_pkg::OP_RD_OFF1;
            end
            rpd_pkg::S_H1: op = i_sts.hdr_long ? rpd_pkg::OP_RD_OFF2 : rpd_pkg::OP_PLEN8;
            rpd_pkg::S_H2: op = rpd_pkg::OP_PLEN16;
            rpd_pkg::S_CHK: begin
                if (!i_sts.len_bad)
                    op = i_sts.tot_short ? rpd_pkg::OP_WAIT_TOT : rpd_pkg::OP_CRC_START;
            end
            rpd_pkg::S_CRC: op = rpd_pkg::OP_CRC_STEP;
            rpd_pkg::S_T0:  op = rpd_pkg::OP_TAIL;
            rpd_pkg::S_T1:  op = rpd_pkg::OP_TAIL;
            rpd_pkg::S_T2: begin
                if (i_sts.trail_ok) op = rpd_pkg::OP_FOUND;
            end
            rpd_pkg::S_BAD: op = rpd_pkg::OP_SLIDE;
            rpd_pkg::S_EMIT: begin
                if (i_sts.out_free) op = rpd_pkg::OP_EMIT;
            end
            default: op = rpd_pkg::OP_NONE;
        endcase
    end

    assign o_cmd.op   = op;
    assign o_cmd.code = r_code;

endmodule

/* sv/rpd_datapath.sv */
// datapath: ring store, scan registers, crc and result register
`timescale 1ns / 1ps
module rpd_datapath #(
    parameter int BUFFER_BYTES      = 1024,
    parameter int MAX_PAYLOAD_BYTES = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rpd_pkg::t_cmd i_cmd,
    output rpd_pkg::t_sts o_sts,
    input  logic [1:0]    i_req_type,
    input  logic [7:0]    i_data_byte,
    input  logic [8:0]    i_read_index,
    input  logic          i_cfg_valid,
    input  logic [9:0]    i_cfg_max_payload,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [1:0]    o_status,
    output logic [9:0]    o_payload_length,
    output logic [7:0]    o_read_data
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int UW = $clog2(BUFFER_BYTES + MAX_PAYLOAD_BYTES + 4);
    localparam logic [CW:0]   BUF_SZ  = (CW + 1)'(BUFFER_BYTES);
    localparam logic [CW-1:0] BUF_CNT = CW'(BUFFER_BYTES);
    localparam logic [16:0]   BUF_TOT = 17'(BUFFER_BYTES);
    localparam logic [15:0]   MAXP    = 16'(MAX_PAYLOAD_BYTES);

    logic [7:0]    r_ring [BUFFER_BYTES];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_ss, r_fps;
    logic [CW-1:0] r_live, r_btw, r_off;
    logic          r_pending;
    logic [LW-1:0] r_flen, r_rem;
    logic [9:0]    r_max;
    logic [1:0]    r_req;
    logic [7:0]    r_byte;
    logic [8:0]    r_ridx;
    logic [1:0]    r_hdr;
    logic [15:0]   r_plen, r_crc, r_rx;
    logic          r_o_valid;

    logic [CW-1:0] live_eff, n_off, hdr_need;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          rd_en;
    logic [16:0]   total;
    logic [UW-1:0] used;
    rpd_pkg::t_op  op;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW + 1)'(a) + (CW + 1)'(b);
        if (s >= BUF_SZ) s = s - BUF_SZ;
        return s[AW-1:0];
    endfunction

    assign op       = i_cmd.op;
    assign live_eff = (r_live >= BUF_CNT) ? '0 : r_live;
    assign wr_addr  = wrap_add(r_ss, live_eff);
    assign total    = 17'(r_hdr) + 17'(r_plen) + 17'd3;
    assign used     = UW'(r_off) + UW'(r_flen) + UW'(3);
    assign hdr_need = (r_rd_data == rpd_pkg::START_SHORT) ? CW'(2) : CW'(3);

    // next scan offset and read address
    always_comb begin
        n_off = r_off;
        rd_en = 1'b1;
        unique case (op)
            rpd_pkg::OP_RD_OFF0:   n_off = '0;
            rpd_pkg::OP_RD_OFF1:   n_off = CW'(1);
            rpd_pkg::OP_RD_OFF2:   n_off = CW'(2);
            rpd_pkg::OP_CRC_START: n_off = CW'(r_hdr);
            rpd_pkg::OP_CRC_STEP:  n_off = r_off + CW'(1);
            rpd_pkg::OP_TAIL:      n_off = r_off + CW'(1);
            rpd_pkg::OP_RD_PAY:    n_off = r_off;
            rpd_pkg::OP_RES_OFF: begin
                rd_en = 1'b0;
                n_off = (r_fps >= r_ss) ? CW'(r_fps - r_ss)
                                        : CW'(BUF_SZ + (CW + 1)'(r_fps) - (CW + 1)'(r_ss));
            end
            rpd_pkg::OP_RES_USED: begin
                rd_en = 1'b0;
                n_off = (used > UW'(r_live)) ? r_live : CW'(used);
            end
            default:               rd_en = 1'b0;
        endcase
        if (op == rpd_pkg::OP_RD_PAY) begin
            rd_addr = wrap_add(r_fps, CW'(r_ridx));
        end else begin
            rd_addr = wrap_add(r_ss, n_off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == rpd_pkg::OP_PUSH) r_ring[wr_addr] <= r_byte;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= r_ring[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss      <= '0;
            r_live    <= '0;
            r_btw     <= '0;
            r_pending <= 1'b0;
            r_fps     <= '0;
            r_flen    <= '0;
            r_max     <= rpd_pkg::MAX_PAYLOAD_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_max <= i_cfg_max_payload;
            if (op == rpd_pkg::OP_EMIT) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (op)
                rpd_pkg::OP_PUSH: begin
                    r_live <= live_eff + CW'(1);
                    if (r_live >= BUF_CNT) r_btw <= '0;
                end
                rpd_pkg::OP_BTW_DEC:  r_btw <= r_btw - CW'(1);
                rpd_pkg::OP_WAIT1:    r_btw <= CW'(1);
                rpd_pkg::OP_WAIT_HDR: r_btw <= hdr_need - r_live;
                rpd_pkg::OP_WAIT_TOT: r_btw <= CW'(total) - r_live;
                rpd_pkg::OP_RES_APPLY: begin
                    r_ss      <= wrap_add(r_ss, r_off);
                    r_live    <= r_live - r_off;
                    r_pending <= 1'b0;
                    r_btw     <= '0;
                end
                rpd_pkg::OP_FOUND: begin
                    r_pending <= 1'b1;
                    r_fps     <= wrap_add(r_ss, CW'(r_hdr));
                    r_flen    <= r_plen[LW-1:0];
                    r_btw     <= '0;
                end
                rpd_pkg::OP_SLIDE: begin
                    r_ss   <= wrap_add(r_ss, CW'(1));
                    r_live <= r_live - CW'(1);
                    r_btw  <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_off <= n_off;
        unique case (op)
            rpd_pkg::OP_LATCH: begin
                r_req  <= i_req_type;
                r_byte <= i_data_byte;
                r_ridx <= i_read_index;
            end
            rpd_pkg::OP_RD_OFF1:  r_hdr <= r_rd_data[1:0];
            rpd_pkg::OP_RD_OFF2:  r_plen[15:8] <= r_rd_data;
            rpd_pkg::OP_PLEN8:    r_plen <= {8'h00, r_rd_data};
            rpd_pkg::OP_PLEN16:   r_plen[7:0] <= r_rd_data;
            rpd_pkg::OP_CRC_START: begin
                r_crc <= '0;
                r_rem <= r_plen[LW-1:0];
            end
            rpd_pkg::OP_CRC_STEP: begin
                r_crc <= rpd_pkg::crc_byte(r_crc, r_rd_data);
                r_rem <= r_rem - LW'(1);
            end
            rpd_pkg::OP_TAIL: r_rx <= {r_rx[7:0], r_rd_data};
            rpd_pkg::OP_EMIT: begin
                o_status         <= i_cmd.code;
                o_payload_length <= r_pending ? 10'(r_flen) : 10'd0;
                o_read_data      <= (i_cmd.code == rpd_pkg::ST_READ) ? r_rd_data : 8'd0;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_o_valid;

    assign o_sts.req       = r_req;
    assign o_sts.pending   = r_pending;
    assign o_sts.full      = (r_live >= BUF_CNT);
    assign o_sts.rd_ok     = (16'(r_ridx) < 16'(r_flen));
    assign o_sts.btw_gt1   = (r_btw > CW'(1));
    assign o_sts.live_zero = (r_live == '0);
    assign o_sts.live_one  = (r_live == CW'(1));
    assign o_sts.b0_is2    = (r_rd_data == rpd_pkg::START_SHORT);
    assign o_sts.b0_is3    = (r_rd_data == rpd_pkg::START_LONG);
    assign o_sts.hdr_short = (r_live < hdr_need);
    assign o_sts.hdr_long  = (r_hdr == rpd_pkg::START_LONG[1:0]);
    assign o_sts.len_bad   = (r_plen == '0) || (r_plen > 16'(r_max)) || (r_plen > MAXP)
                          || ((r_hdr == rpd_pkg::START_LONG[1:0]) && (r_plen < rpd_pkg::LONG_MIN))
                          || (total > BUF_TOT);
    assign o_sts.tot_short = (17'(r_live) < total);
    assign o_sts.crc_last  = (r_rem == LW'(1));
    assign o_sts.trail_ok  = (r_rd_data == rpd_pkg::END_BYTE) && (r_rx == r_crc);
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

endmodule

/* sv/resync_packet_deframer_crc16.sv */
// top level: length-prefixed frame receiver with crc-16 check and resync scan
`timescale 1ns / 1ps
// Bytes pushed in land in a ring store of BUFFER_BYTES entries; after each push the
// block scans for a frame (start 2 with 8-bit length, or start 3 with 16-bit length of
// at least 255, payload, big-endian crc-16 poly 0x1021 init 0, end byte 3). A found
// frame is held until resume; its payload is read back one byte per request. Every
// request gives one result transfer. A scan reads the start byte, then the length,
// then one payload byte at a time into the crc, then crc and trailer; a rejected
// candidate slides the start by one byte and rescans from the next byte, and resume
// first steps the start past the held frame before its scan. The ring store has a
// single read port: one stored byte is examined per cycle. A new request is taken
// while the previous result still waits in the output register.
module resync_packet_deframer_crc16 #(
    parameter int BUFFER_BYTES      = 1024,
    parameter int MAX_PAYLOAD_BYTES = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpd_in_if.sink     i_in,
    rpd_out_if.source  o_out,
    rpd_cfg_if.sink    i_cfg
);

    rpd_pkg::t_cmd cmd;
    rpd_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    rpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rpd_datapath #(
        .BUFFER_BYTES      (BUFFER_BYTES),
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_req_type        (i_in.req_type),
        .i_data_byte       (i_in.data_byte),
        .i_read_index      (i_in.read_index),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_max_payload (i_cfg.max_payload),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_status          (o_out.status),
        .o_payload_length  (o_out.payload_length),
        .o_read_data       (o_out.read_data)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while previous one in flight");

    a_found_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == rpd_pkg::ST_FOUND || o_out.status == rpd_pkg::ST_READ))
        |-> (o_out.payload_length != 10'd0))
        else $error("held frame reported with zero length");

    a_data_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != rpd_pkg::ST_READ) |-> (o_out.read_data == 8'd0))
        else $error("read data on a non-read result");

endmodule
